### rtl/core/mfcr_pkg.sv
// Package for the Modbus frame check responder: constants, types and the CRC byte update.
package mfcr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned REPLY_IDX_W = 3;

    localparam logic [CRC_W-1:0]   CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY  = 16'hA001;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [COUNT_W-1:0] MIN_FRAME = 8'd8;
    localparam logic [BYTE_W-1:0]  READ_FUNC = 8'h03;
    localparam logic [BYTE_W-1:0]  BYTE_CNT  = 8'h02;

    localparam logic [BYTE_W-1:0]  OWN_ADDR_RESET    = 8'h01;
    localparam logic [CFG_DAT_W-1:0] REPLY_VAL_RESET = 16'h1234;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_ADDRESS = 1'b0,
        REG_REPLY_VALUE = 1'b1
    } t_cfg_reg;

    // Position of a byte within a seven-byte reply.
    typedef enum logic [REPLY_IDX_W-1:0] {
        RPL_ADDR   = 3'd0,
        RPL_FUNC   = 3'd1,
        RPL_COUNT  = 3'd2,
        RPL_VAL_HI = 3'd3,
        RPL_VAL_LO = 3'd4,
        RPL_CRC_LO = 3'd5,
        RPL_CRC_HI = 3'd6
    } t_reply_idx;

    // One byte of CRC-16/MODBUS, reflected, one bit per step.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/modbus_frame_check_responder.sv
// Modbus RTU read-request checker and responder, top level.
//
//  Channel  Direction  Handshake               Payload
//  rx       in         i_rx_valid / o_rx_stall i_rx_byte, i_frame_end
//  tx       out        o_tx_valid / i_tx_stall o_tx_byte, o_tx_last, o_frame_ok
//  cfg      in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A new beat can be taken in every cycle unless it is a frame end held by the sequencer.
// A frame end that the block accepts loads the reply sequencer, which hands out one result
// beat per cycle unless the output stalls: seven for an accepted, one for a rejected frame.
// The reply sequencer is the only thing that holds the input: a frame end beat is stalled
// while an earlier reply still has beats to hand to the output register, while bytes that
// do not end a frame are always taken. The output register holds a beat under i_tx_stall.
// Reset is synchronous and active low; it restores the configuration registers and clears
// the frame CRC, count and delay and the busy and valid flags. There is no clearing pass.
module modbus_frame_check_responder
    import mfcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received bytes
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_frame_end,
    // reply bytes
    output logic                 o_tx_valid,
    input  logic                 i_tx_stall,
    output logic [BYTE_W-1:0]    o_tx_byte,
    output logic                 o_tx_last,
    output logic                 o_frame_ok,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [BYTE_W-1:0]    r_own_addr;
    logic [CFG_DAT_W-1:0] r_reply_val;

    // Frame state. The last two bytes seen sit in a two-byte delay and only enter the CRC
    // once a newer byte pushes them out, so the frame's own CRC bytes never reach it.
    logic [CRC_W-1:0]   r_crc;
    logic [COUNT_W-1:0] r_count;
    logic [BYTE_W-1:0]  r_held0;
    logic [BYTE_W-1:0]  r_held1;
    logic [BYTE_W-1:0]  r_first;
    logic [BYTE_W-1:0]  r_second;

    // Reply sequencer.
    logic               r_gen_busy;
    logic               r_gen_ok;
    t_reply_idx         r_gen_idx;
    logic [CRC_W-1:0]   r_gen_crc;

    // Output register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_ok;

    logic               rx_accept;
    logic               out_ready;
    logic               gen_fire;
    logic               gen_last;
    logic [BYTE_W-1:0]  gen_byte;
    logic [CRC_W-1:0]   n_gen_crc;

    logic [COUNT_W-1:0] n_count;
    logic [CRC_W-1:0]   n_crc;
    logic [BYTE_W-1:0]  n_first;
    logic [BYTE_W-1:0]  n_second;
    logic               frame_good;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign out_ready = !r_out_valid || !i_tx_stall;
    assign gen_fire  = r_gen_busy && out_ready;
    assign gen_last  = !r_gen_ok || (r_gen_idx == RPL_CRC_HI);

    // A frame end may enter in the same cycle as the previous reply's last beat leaves.
    assign o_rx_stall = i_frame_end && r_gen_busy && !(gen_fire && gen_last);
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    // ------------------------------------------------------------------
    // Frame check for the incoming byte
    // ------------------------------------------------------------------
    always_comb begin
        n_count  = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        n_crc    = (r_count >= 8'd2) ? crc_feed(r_crc, r_held0) : r_crc;
        n_first  = (r_count == 8'd0) ? i_rx_byte : r_first;
        n_second = (r_count == 8'd1) ? i_rx_byte : r_second;
        // The received CRC is the last two bytes, low byte first.
        frame_good = (n_count >= MIN_FRAME)
                  && ({i_rx_byte, r_held1} == n_crc)
                  && (n_first == r_own_addr)
                  && (n_second == READ_FUNC);
    end

    // ------------------------------------------------------------------
    // Reply byte selection. The reply CRC is built one byte per beat as the
    // bytes go out, so it is ready when its two bytes are due.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_gen_idx)
            RPL_ADDR:   gen_byte = r_own_addr;
            RPL_FUNC:   gen_byte = READ_FUNC;
            RPL_COUNT:  gen_byte = BYTE_CNT;
            RPL_VAL_HI: gen_byte = r_reply_val[15:8];
            RPL_VAL_LO: gen_byte = r_reply_val[7:0];
            RPL_CRC_LO: gen_byte = r_gen_crc[7:0];
            RPL_CRC_HI: gen_byte = r_gen_crc[15:8];
            default:    gen_byte = '0;
        endcase
        if (!r_gen_ok) begin
            gen_byte = '0;
        end
        n_gen_crc = crc_feed(r_gen_crc, gen_byte);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= OWN_ADDR_RESET;
            r_reply_val <= REPLY_VAL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OWN_ADDRESS: r_own_addr  <= i_cfg_data[BYTE_W-1:0];
                REG_REPLY_VALUE: r_reply_val <= i_cfg_data;
                default:         r_reply_val <= r_reply_val;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
        end else if (rx_accept) begin
            if (i_frame_end) begin
                r_crc   <= CRC_INIT;
                r_count <= '0;
                r_held0 <= '0;
                r_held1 <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
                r_held0 <= r_held1;
                r_held1 <= i_rx_byte;
            end
        end
    end

    // Address and function bytes are only looked at once the count shows them written.
    always_ff @(posedge i_clk) begin
        if (rx_accept && !i_frame_end) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // ------------------------------------------------------------------
    // Reply sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_busy  <= 1'b0;
            r_gen_idx   <= RPL_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            if (gen_fire) begin
                r_out_valid <= 1'b1;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
            // A new frame end takes over the sequencer as the old reply's last beat leaves.
            if (rx_accept && i_frame_end) begin
                r_gen_busy <= 1'b1;
                r_gen_idx  <= RPL_ADDR;
            end else if (gen_fire) begin
                if (gen_last) begin
                    r_gen_busy <= 1'b0;
                end else begin
                    r_gen_idx <= t_reply_idx'(r_gen_idx + 1'b1);
                end
            end
        end
    end

    // The reply CRC covers the five header and value bytes only; it stays put while
    // its own two bytes go out.
    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_out_byte <= gen_byte;
            r_out_last <= gen_last;
            r_out_ok   <= r_gen_ok;
        end
        if (rx_accept && i_frame_end) begin
            r_gen_ok  <= frame_good;
            r_gen_crc <= CRC_INIT;
        end else if (gen_fire && (r_gen_idx < RPL_CRC_LO)) begin
            r_gen_crc <= n_gen_crc;
        end
    end

    assign o_tx_valid = r_out_valid;
    assign o_tx_byte  = r_out_byte;
    assign o_tx_last  = r_out_last;
    assign o_frame_ok = r_out_ok;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A rejection is a single zero beat that closes the run.
    a_reject_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_last && (r_out_byte == 8'h00))
        else $error("rejection beat is not a single zero byte");

    // The sequencer never walks past the last reply byte.
    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen_busy |-> (r_gen_idx <= RPL_CRC_HI))
        else $error("reply sequencer index out of range");

    // An accepted frame end always starts a fresh reply.
    a_gen_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_accept && i_frame_end |=> r_gen_busy && (r_gen_idx == RPL_ADDR))
        else $error("frame end did not start the reply sequencer");

    // The CRC stays at its start value until a third byte pushes the first out of the delay.
    a_crc_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 8'd2) |-> (r_crc == CRC_INIT))
        else $error("CRC moved before the delay was full");

endmodule
